// ----- hw/rtl/kth_present_removal_top_macros.svh -----
`ifndef KTH_PRESENT_REMOVAL_TOP_MACROS_SVH
`define KTH_PRESENT_REMOVAL_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define KPR_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`define KPR_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`else

`define KPR_ASSERT_NOW(name, pre, post, msg)
`define KPR_ASSERT_NEXT(name, pre, post, msg)

`endif

`endif

// ----- hw/rtl/kpr_pkg.sv -----
package kpr_pkg;

  localparam int unsigned CAPACITY  = 1024;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned POS_W     = 11;
  localparam int unsigned LEN_W     = 11;
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned SLOT_W    = $clog2(CAPACITY);
  localparam int unsigned IDX_W     = CNT_W + 1;
  localparam int unsigned CMP_W     = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
  localparam int unsigned TOP_STEP  = 1 << ($clog2(CAPACITY + 1) - 1);
  localparam int unsigned LEN_RESET = 1024;

  localparam int unsigned IN_DATA_W  = ((VAL_W + POS_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((VAL_W + 7) / 8) * 8;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

endpackage

// ----- hw/rtl/kth_present_removal_top.sv -----
// Channel     | Dir | tdata                                 | tuser
// s_axis      | in  | [31:0] value, [42:32] position        | kind
// m_axis      | out | [31:0] removed_value                  | status
// cfg         | in  | cfg_wdata_i: list_length              | -
// After reset the count tree is swept to zero, one entry a cycle; no request is taken meanwhile.
// A load is accepted, then the update pass does one tree write a level; a load beyond the list
// is accepted and dropped.
// A remove is accepted, then the descent does one tree read a level, then the update pass and the
// emit state follow; a bad rank goes from accept straight to emit.
// A result waits in the output register while a new request is taken; the next one holds.
`include "kth_present_removal_top_macros.svh"

module kth_present_removal_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [kpr_pkg::LEN_W-1:0]      cfg_wdata_i,    // list_length
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [kpr_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // value, position, zero pad
  input  logic                           s_axis_tuser,   // kind
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [kpr_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // removed_value
  output logic                           m_axis_tuser    // status
);
  import kpr_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FIND  = 3'd2;
  localparam logic [2:0] ST_UPD   = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [VAL_W-1:0] value_mem [CAPACITY];
  logic [CNT_W-1:0] tree_mem  [CAPACITY + 1];

  logic [2:0]       state_q, state_d;
  logic [LEN_W-1:0] len_q;
  logic [CNT_W-1:0] loaded_q, loaded_d;
  logic [CNT_W-1:0] present_q, present_d;
  logic [CNT_W-1:0] clr_addr_q, clr_addr_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] step_q, step_d;
  logic [POS_W-1:0] k_q, k_d;
  logic             rd_ok_q, rd_ok_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             up_q, up_d;
  logic             rm_q, rm_d;
  logic             err_q, err_d;
  logic             out_valid_q, out_valid_d;
  logic [VAL_W-1:0] out_val_q, out_val_d;
  logic             out_err_q, out_err_d;

  logic             tree_we, tree_re;
  logic [CNT_W-1:0] tree_waddr, tree_raddr, tree_wdata, tree_rdata_q;
  logic             vs_we, vs_re;
  logic [SLOT_W-1:0] vs_waddr, vs_raddr;
  logic [VAL_W-1:0] vs_wdata, vs_rdata_q;

  logic             in_fire;
  logic [VAL_W-1:0] in_value;
  logic [POS_W-1:0] in_pos;
  logic [CNT_W-1:0] limit;
  logic [IDX_W-1:0] cur_nxt, probe, nidx;
  logic [CNT_W-1:0] pos_n, next_step, slot, lowbit;
  logic             take, probe_ok, find_last;

  assign in_value = s_axis_tdata[VAL_W-1:0];
  assign in_pos   = s_axis_tdata[VAL_W+POS_W-1:VAL_W];
  assign limit    = (CMP_W'(len_q) > CMP_W'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(len_q);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_val_q);
  assign m_axis_tuser  = out_err_q;

  // descent step
  assign cur_nxt   = IDX_W'(pos_q) + IDX_W'(step_q);
  assign take      = rd_ok_q && (CMP_W'(tree_rdata_q) < CMP_W'(k_q));
  assign pos_n     = take ? cur_nxt[CNT_W-1:0] : pos_q;
  assign next_step = step_q >> 1;
  assign probe     = IDX_W'(pos_n) + IDX_W'(next_step);
  assign probe_ok  = (probe <= IDX_W'(CAPACITY));
  assign slot      = (pos_n >= CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY - 1) : pos_n;
  assign find_last = (state_q == ST_FIND) && (step_q == CNT_W'(1));

  // update pass step
  assign lowbit = idx_q & (~idx_q + CNT_W'(1));
  assign nidx   = IDX_W'(idx_q) + IDX_W'(lowbit);

  always_comb begin
    state_d     = state_q;
    loaded_d    = loaded_q;
    present_d   = present_q;
    clr_addr_d  = clr_addr_q;
    pos_d       = pos_q;
    step_d      = step_q;
    k_d         = k_q;
    rd_ok_d     = rd_ok_q;
    idx_d       = idx_q;
    up_d        = up_q;
    rm_d        = rm_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    out_val_d   = out_val_q;
    out_err_d   = out_err_q;
    tree_we     = 1'b0;
    tree_waddr  = idx_q;
    tree_wdata  = '0;
    tree_re     = 1'b0;
    tree_raddr  = idx_q;
    vs_we       = 1'b0;
    vs_waddr    = loaded_q[SLOT_W-1:0];
    vs_wdata    = in_value;
    vs_re       = 1'b0;
    vs_raddr    = slot[SLOT_W-1:0];

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        tree_we    = 1'b1;
        tree_waddr = clr_addr_q;
        if (clr_addr_q == CNT_W'(CAPACITY)) begin
          state_d = ST_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + CNT_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser == KIND_LOAD) begin
            if (loaded_q < limit) begin
              vs_we      = 1'b1;
              tree_re    = 1'b1;
              tree_raddr = loaded_q + CNT_W'(1);
              idx_d      = loaded_q + CNT_W'(1);
              loaded_d   = loaded_q + CNT_W'(1);
              present_d  = present_q + CNT_W'(1);
              up_d       = 1'b1;
              rm_d       = 1'b0;
              state_d    = ST_UPD;
            end
          end else if (in_pos == '0 || CMP_W'(in_pos) > CMP_W'(present_q)) begin
            err_d   = STATUS_ERR;
            state_d = ST_EMIT;
          end else begin
            tree_re    = 1'b1;
            tree_raddr = CNT_W'(TOP_STEP);
            pos_d      = '0;
            step_d     = CNT_W'(TOP_STEP);
            k_d        = in_pos;
            rd_ok_d    = 1'b1;
            state_d    = ST_FIND;
          end
        end
      end
      ST_FIND: begin
        pos_d = pos_n;
        if (take) begin
          k_d = k_q - POS_W'(tree_rdata_q);
        end
        if (find_last) begin
          vs_re      = 1'b1;
          tree_re    = 1'b1;
          tree_raddr = slot + CNT_W'(1);
          idx_d      = slot + CNT_W'(1);
          up_d       = 1'b0;
          rm_d       = 1'b1;
          err_d      = STATUS_OK;
          present_d  = present_q - CNT_W'(1);
          if (present_q == CNT_W'(1)) begin
            loaded_d = '0;
          end
          state_d = ST_UPD;
        end else begin
          step_d     = next_step;
          tree_re    = probe_ok;
          tree_raddr = probe[CNT_W-1:0];
          rd_ok_d    = probe_ok;
        end
      end
      ST_UPD: begin
        tree_we    = 1'b1;
        tree_waddr = idx_q;
        tree_wdata = up_q ? tree_rdata_q + CNT_W'(1) : tree_rdata_q - CNT_W'(1);
        if (nidx <= IDX_W'(CAPACITY)) begin
          tree_re    = 1'b1;
          tree_raddr = nidx[CNT_W-1:0];
          idx_d      = nidx[CNT_W-1:0];
        end else begin
          state_d = rm_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_val_d   = (err_q == STATUS_ERR) ? '0 : vs_rdata_q;
          out_err_d   = err_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      len_q       <= LEN_W'(LEN_RESET);
      loaded_q    <= '0;
      present_q   <= '0;
      clr_addr_q  <= '0;
      pos_q       <= '0;
      step_q      <= '0;
      k_q         <= '0;
      rd_ok_q     <= 1'b0;
      idx_q       <= '0;
      up_q        <= 1'b0;
      rm_q        <= 1'b0;
      err_q       <= STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      loaded_q    <= loaded_d;
      present_q   <= present_d;
      clr_addr_q  <= clr_addr_d;
      pos_q       <= pos_d;
      step_q      <= step_d;
      k_q         <= k_d;
      rd_ok_q     <= rd_ok_d;
      idx_q       <= idx_d;
      up_q        <= up_d;
      rm_q        <= rm_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_val_q <= out_val_d;
    out_err_q <= out_err_d;
  end

  always_ff @(posedge clk_i) begin
    if (vs_we) begin
      value_mem[vs_waddr] <= vs_wdata;
    end
    if (vs_re) begin
      vs_rdata_q <= value_mem[vs_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tree_we) begin
      tree_mem[tree_waddr] <= tree_wdata;
    end
    if (tree_re) begin
      tree_rdata_q <= tree_mem[tree_raddr];
    end
  end

  `KPR_ASSERT_NOW(a_present_le_loaded, 1'b1, present_q <= loaded_q, "present above loaded")
  `KPR_ASSERT_NOW(a_loaded_le_cap, 1'b1, loaded_q <= CNT_W'(CAPACITY), "loaded above capacity")
  `KPR_ASSERT_NOW(a_rank_nonzero, state_q == ST_FIND, k_q != '0, "rank reached zero in descent")
  `KPR_ASSERT_NOW(a_no_rw_clash, tree_we && tree_re, tree_waddr != tree_raddr, "tree rw clash")
  `KPR_ASSERT_NEXT(a_find_to_upd, find_last, state_q == ST_UPD, "descent not followed by update")

endmodule
